// ----- rtl/lds_pkg.sv -----
// Shared types and constants for the locker door sequencer.
package lds_pkg;

    typedef enum logic [2:0] {
        ST_CLOSED  = 3'd0,
        ST_OPENING = 3'd1,
        ST_PICKUP  = 3'd2,
        ST_CLOSING = 3'd3,
        ST_FAULT   = 3'd4
    } state_t;

    typedef enum logic [1:0] {
        FC_NONE         = 2'd0,
        FC_OPEN_TIMEOUT = 2'd1,
        FC_CLOSE_TIMEOUT = 2'd2
    } fault_t;

    typedef enum logic [1:0] {
        PC_NONE       = 2'd0,
        PC_CLOSED     = 2'd1,
        PC_OPEN_EVENT = 2'd2,
        PC_FAULT      = 2'd3
    } persist_t;

    typedef enum logic {
        KIND_TICK    = 1'b0,
        KIND_REQUEST = 1'b1
    } kind_t;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned TMO_W    = 20;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_ITEM_SENSOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PICKUP_LIMIT_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LIMIT_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CLEAR_MS    = 3'd4;

    localparam logic [TMO_W-1:0] RST_OPEN_LIMIT_MS   = 20'd5000;
    localparam logic [TMO_W-1:0] RST_PICKUP_LIMIT_MS = 20'd30000;
    localparam logic [TMO_W-1:0] RST_CLOSE_LIMIT_MS  = 20'd5000;
    localparam logic [TMO_W-1:0] RST_KEY_CLEAR_MS    = 20'd3000;

    typedef struct packed {
        logic              use_item_sensor;
        logic [TMO_W-1:0]  open_limit_ms;
        logic [TMO_W-1:0]  pickup_limit_ms;
        logic [TMO_W-1:0]  close_limit_ms;
        logic [TMO_W-1:0]  key_clear_ms;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [TIME_W-1:0]  now_ms;
        logic               door_is_open;
        logic               item_seen;
        logic               key_pressed;
    } item_t;

    typedef struct packed {
        state_t    cabinet_state;
        fault_t    fault_cause;
        logic      unlock_pulse;
        logic      lock_pulse;
        persist_t  persist_code;
        logic      request_accepted;
    } result_t;

endpackage

// ----- rtl/lds_cfg_regs.sv -----
// Configuration register bank of the locker door sequencer.
module lds_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lds_pkg::TMO_W-1:0]      cfg_wdata,
    output lds_pkg::cfg_t                  cfg
);
    import lds_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_item_sensor <= 1'b0;
            cfg_reg.open_limit_ms   <= RST_OPEN_LIMIT_MS;
            cfg_reg.pickup_limit_ms <= RST_PICKUP_LIMIT_MS;
            cfg_reg.close_limit_ms  <= RST_CLOSE_LIMIT_MS;
            cfg_reg.key_clear_ms    <= RST_KEY_CLEAR_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_USE_ITEM_SENSOR: cfg_reg.use_item_sensor <= cfg_wdata[0];
                CFG_OPEN_LIMIT_MS:   cfg_reg.open_limit_ms   <= cfg_wdata;
                CFG_PICKUP_LIMIT_MS: cfg_reg.pickup_limit_ms <= cfg_wdata;
                CFG_CLOSE_LIMIT_MS:  cfg_reg.close_limit_ms  <= cfg_wdata;
                CFG_KEY_CLEAR_MS:    cfg_reg.key_clear_ms    <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/lds_in_reg.sv -----
// Input register stage: holds one accepted transfer until the core takes it.
module lds_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_valid,
    output logic           s_ready,
    input  lds_pkg::item_t s_item,
    input  logic           take,
    output logic           vld,
    output lds_pkg::item_t item
);
    import lds_pkg::*;

    logic  vld_reg;
    item_t item_reg;

    assign s_ready = !vld_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            item_reg <= s_item;
        end
    end

    assign vld  = vld_reg;
    assign item = item_reg;

endmodule

// ----- rtl/lds_seq_core.sv -----
// Sequencer state registers and the single-pass next-state logic.
module lds_seq_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  lds_pkg::item_t   item,
    input  lds_pkg::cfg_t    cfg,
    output lds_pkg::result_t result
);
    import lds_pkg::*;

    state_t              state_reg,     state_next;
    fault_t              fault_reg,     fault_next;
    logic [TIME_W-1:0]   entry_reg,     entry_next;
    logic                pending_reg,   pending_next;
    logic                held_reg,      held_next;
    logic [TIME_W-1:0]   press_reg,     press_next;

    logic [TIME_W-1:0]   elapsed;
    logic [TIME_W-1:0]   key_elapsed;
    state_t              st_mid;
    logic                unlock;
    logic                lock;
    persist_t            persist;
    logic                accepted;

    assign elapsed     = item.now_ms - entry_reg;
    assign key_elapsed = item.now_ms - press_reg;

    always_comb
    begin
        state_next   = state_reg;
        fault_next   = fault_reg;
        entry_next   = entry_reg;
        pending_next = pending_reg;
        held_next    = held_reg;
        press_next   = press_reg;
        unlock       = 1'b0;
        lock         = 1'b0;
        persist      = PC_NONE;
        accepted     = 1'b0;
        st_mid       = state_reg;

        if (item.kind == KIND_REQUEST)
        begin
            if (state_reg == ST_CLOSED)
            begin
                pending_next = 1'b1;
                accepted     = 1'b1;
            end
        end
        else
        begin
            // service key: first tick records press time, hold clears a fault
            if (item.key_pressed)
            begin
                if (!held_reg)
                begin
                    press_next = item.now_ms;
                    held_next  = 1'b1;
                end
                else if (key_elapsed >= {{(TIME_W-TMO_W){1'b0}}, cfg.key_clear_ms})
                begin
                    if (state_reg == ST_FAULT)
                    begin
                        fault_next = FC_NONE;
                        st_mid     = ST_CLOSED;
                        entry_next = item.now_ms;
                        persist    = PC_CLOSED;
                    end
                    press_next = item.now_ms;
                end
            end
            else
            begin
                held_next = 1'b0;
            end

            state_next = st_mid;

            unique case (st_mid)
                ST_CLOSED:
                begin
                    if (pending_reg)
                    begin
                        pending_next = 1'b0;
                        unlock       = 1'b1;
                        persist      = PC_OPEN_EVENT;
                        state_next   = ST_OPENING;
                        entry_next   = item.now_ms;
                    end
                end
                ST_OPENING:
                begin
                    if (item.door_is_open && (!cfg.use_item_sensor || item.item_seen))
                    begin
                        state_next = ST_PICKUP;
                        entry_next = item.now_ms;
                    end
                    else if (elapsed >= {{(TIME_W-TMO_W){1'b0}}, cfg.open_limit_ms})
                    begin
                        fault_next = FC_OPEN_TIMEOUT;
                        lock       = 1'b1;
                        state_next = ST_FAULT;
                        entry_next = item.now_ms;
                        persist    = PC_FAULT;
                    end
                end
                ST_PICKUP:
                begin
                    if ((cfg.use_item_sensor && !item.item_seen) ||
                        elapsed >= {{(TIME_W-TMO_W){1'b0}}, cfg.pickup_limit_ms})
                    begin
                        lock       = 1'b1;
                        state_next = ST_CLOSING;
                        entry_next = item.now_ms;
                    end
                end
                ST_CLOSING:
                begin
                    if (!item.door_is_open)
                    begin
                        state_next = ST_CLOSED;
                        entry_next = item.now_ms;
                        persist    = PC_CLOSED;
                    end
                    else if (elapsed >= {{(TIME_W-TMO_W){1'b0}}, cfg.close_limit_ms})
                    begin
                        fault_next = FC_CLOSE_TIMEOUT;
                        lock       = 1'b1;
                        state_next = ST_FAULT;
                        entry_next = item.now_ms;
                        persist    = PC_FAULT;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLOSED;
            fault_reg   <= FC_NONE;
            entry_reg   <= '0;
            pending_reg <= 1'b0;
            held_reg    <= 1'b0;
            press_reg   <= '0;
        end
        else if (fire)
        begin
            state_reg   <= state_next;
            fault_reg   <= fault_next;
            entry_reg   <= entry_next;
            pending_reg <= pending_next;
            held_reg    <= held_next;
            press_reg   <= press_next;
        end
    end

    assign result.cabinet_state    = state_next;
    assign result.fault_cause      = fault_next;
    assign result.unlock_pulse     = unlock;
    assign result.lock_pulse       = lock;
    assign result.persist_code     = persist;
    assign result.request_accepted = accepted;

endmodule

// ----- rtl/lds_out_reg.sv -----
// Result register: holds one result until the downstream side takes it.
module lds_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  lds_pkg::result_t result,
    output logic             space,
    output logic             m_valid,
    input  logic             m_ready,
    output lds_pkg::result_t m_result
);
    import lds_pkg::*;

    logic    vld_reg;
    result_t res_reg;

    assign space = !vld_reg || m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (space)
        begin
            vld_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_valid  = vld_reg;
    assign m_result = res_reg;

endmodule

// ----- rtl/locker_door_sequencer_unit.sv -----
// Top level of the locker door sequencer.
// Path: an input transfer is held in the input register, then the sequencer logic
// writes its result into the result register, which offers it downstream.
// Throughput: one item per cycle while the result register has space; the whole state update is one pass of logic.
// Reset: rst_n clears state to closed, no fault, timers zero, config to defaults.
module locker_door_sequencer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [39:0]                   s_axis_tdata,  // now_ms, door_is_open, item_seen,
                                                         // key_pressed, pad
    input  logic                          s_axis_tuser,  // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // cabinet_state, fault_cause, unlock_pulse,
                                                         // lock_pulse, persist_code, request_accepted, pad
    input  logic                          cfg_we,
    input  logic [lds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lds_pkg::TMO_W-1:0]     cfg_wdata
);
    import lds_pkg::*;

    cfg_t    cfg;
    item_t   s_item;
    item_t   item;
    logic    in_vld;
    logic    space;
    logic    fire;
    result_t result;
    result_t m_result;

    assign s_item.kind         = kind_t'(s_axis_tuser);
    assign s_item.now_ms       = s_axis_tdata[31:0];
    assign s_item.door_is_open = s_axis_tdata[32];
    assign s_item.item_seen    = s_axis_tdata[33];
    assign s_item.key_pressed  = s_axis_tdata[34];

    assign fire = in_vld && space;

    lds_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lds_in_reg u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (s_item),
        .take    (fire),
        .vld     (in_vld),
        .item    (item)
    );

    lds_seq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    lds_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .result   (result),
        .space    (space),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (m_result)
    );

    assign m_axis_tdata = {6'b0,
                           m_result.request_accepted,
                           m_result.persist_code,
                           m_result.lock_pulse,
                           m_result.unlock_pulse,
                           m_result.fault_cause,
                           m_result.cabinet_state};

endmodule

// ----- sim/locker_door_sequencer_unit_tb.sv -----
// Self-checking testbench for the locker door sequencer: stream stimulus, in-bench prediction.
`timescale 1ns / 1ps

module locker_door_sequencer_unit_tb;
    import lds_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned ITEMS_TARGET   = 1300;
    localparam int unsigned REPORT_CAP     = 200;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [39:0]          s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [15:0]          m_axis_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TMO_W-1:0]     cfg_wdata;

    locker_door_sequencer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // sequencer mirror
    state_t           lk_state;
    fault_t           lk_fault;
    logic [31:0]      lk_entry;
    logic             lk_pending;
    logic             lk_key_held;
    logic [31:0]      lk_key_t;
    logic             cf_use_item;
    logic [TMO_W-1:0] cf_open_tmo;
    logic [TMO_W-1:0] cf_pickup_tmo;
    logic [TMO_W-1:0] cf_close_tmo;
    logic [TMO_W-1:0] cf_key_clear;

    result_t          door_results_q[$];
    logic [31:0]      tb_now;
    int unsigned      items_sent;
    int unsigned      error_count;
    int unsigned      idle_cycles;
    int unsigned      rx_hold_req;
    logic             tx_steady;
    logic             rx_steady;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void enter_state(input state_t nxt, input logic [31:0] now,
                                        inout persist_t pc);
        if (nxt != lk_state)
        begin
            lk_state = nxt;
            lk_entry = now;
            if (nxt == ST_CLOSED)
                pc = PC_CLOSED;
            else if (nxt == ST_FAULT)
                pc = PC_FAULT;
        end
    endfunction

    function automatic result_t predict_door(kind_t kind, logic [31:0] now, logic door,
                                             logic item, logic key);
        result_t     r;
        persist_t    pc;
        logic [31:0] elapsed;
        logic [31:0] held;
        logic        unl;
        logic        lck;
        logic        acc;
        pc  = PC_NONE;
        unl = 1'b0;
        lck = 1'b0;
        acc = 1'b0;
        if (kind == KIND_REQUEST)
        begin
            if (lk_state == ST_CLOSED)
            begin
                lk_pending = 1'b1;
                acc = 1'b1;
            end
        end
        else
        begin
            elapsed = now - lk_entry;
            if (key)
            begin
                held = now - lk_key_t;
                if (!lk_key_held)
                begin
                    lk_key_t    = now;
                    lk_key_held = 1'b1;
                end
                else if (held >= {12'd0, cf_key_clear})
                begin
                    if (lk_state == ST_FAULT)
                    begin
                        lk_fault = FC_NONE;
                        enter_state(ST_CLOSED, now, pc);
                    end
                    lk_key_t = now;
                end
            end
            else
                lk_key_held = 1'b0;

            case (lk_state)
                ST_CLOSED:
                begin
                    if (lk_pending)
                    begin
                        lk_pending = 1'b0;
                        unl = 1'b1;
                        pc  = PC_OPEN_EVENT;
                        enter_state(ST_OPENING, now, pc);
                    end
                end
                ST_OPENING:
                begin
                    if (door && (!cf_use_item || item))
                        enter_state(ST_PICKUP, now, pc);
                    else if (elapsed >= {12'd0, cf_open_tmo})
                    begin
                        lk_fault = FC_OPEN_TIMEOUT;
                        lck = 1'b1;
                        enter_state(ST_FAULT, now, pc);
                    end
                end
                ST_PICKUP:
                begin
                    if ((cf_use_item && !item) || elapsed >= {12'd0, cf_pickup_tmo})
                    begin
                        lck = 1'b1;
                        enter_state(ST_CLOSING, now, pc);
                    end
                end
                ST_CLOSING:
                begin
                    if (!door)
                        enter_state(ST_CLOSED, now, pc);
                    else if (elapsed >= {12'd0, cf_close_tmo})
                    begin
                        lk_fault = FC_CLOSE_TIMEOUT;
                        lck = 1'b1;
                        enter_state(ST_FAULT, now, pc);
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.cabinet_state    = lk_state;
        r.fault_cause      = lk_fault;
        r.unlock_pulse     = unl;
        r.lock_pulse       = lck;
        r.persist_code     = pc;
        r.request_accepted = acc;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(0, 2);
    endfunction

    function automatic logic pick_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [31:0] pick_delta();
        case ($urandom_range(0, 31))
            0:       return $urandom();
            1, 2, 3: return $urandom_range(0, 200);
            default: return $urandom_range(0, 12);
        endcase
    endfunction

    function automatic logic [TMO_W-1:0] pick_timeout();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return TMO_W'($urandom_range(0, 1048575));
            default: return TMO_W'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic send_item(kind_t kind, logic [31:0] now, logic door, logic item,
                             logic key);
        int unsigned gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'd0, key, item, door, now};
        do
            @(posedge clk);
        while (!s_axis_tready);
        door_results_q.push_back(predict_door(kind, now, door, item, key));
        items_sent++;
        gap = tx_steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic tick_at(logic [31:0] now, logic door, logic item, logic key);
        tb_now = now;
        send_item(KIND_TICK, now, door, item, key);
    endtask

    task automatic tick(logic [31:0] delta, logic door, logic item, logic key);
        tick_at(tb_now + delta, door, item, key);
    endtask

    // timestamp and levels ride along but are ignored
    task automatic send_request();
        send_item(KIND_REQUEST, $urandom(), pick_bit(), pick_bit(), pick_bit());
    endtask

    task automatic finish_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (door_results_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TMO_W-1:0] val);
        case (idx)
            CFG_USE_ITEM_SENSOR: cf_use_item   = val[0];
            CFG_OPEN_LIMIT_MS:   cf_open_tmo   = val;
            CFG_PICKUP_LIMIT_MS: cf_pickup_tmo = val;
            CFG_CLOSE_LIMIT_MS:  cf_close_tmo  = val;
            CFG_KEY_CLEAR_MS:    cf_key_clear  = val;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(logic use_item, logic [TMO_W-1:0] open_tmo,
                              logic [TMO_W-1:0] pickup_tmo, logic [TMO_W-1:0] close_tmo,
                              logic [TMO_W-1:0] key_clear);
        finish_results();
        write_reg(CFG_USE_ITEM_SENSOR, {19'd0, use_item});
        write_reg(CFG_OPEN_LIMIT_MS, open_tmo);
        write_reg(CFG_PICKUP_LIMIT_MS, pickup_tmo);
        write_reg(CFG_CLOSE_LIMIT_MS, close_tmo);
        write_reg(CFG_KEY_CLEAR_MS, key_clear);
    endtask

    // default settings: opening timeout to fault, key clear back to closed
    task automatic test_reset_defaults();
        tick_at(32'd0, 1'b0, 1'b0, 1'b0);
        send_request();
        tick_at(32'd100, 1'b0, 1'b0, 1'b0);
        send_request();
        tick_at(32'd5099, 1'b0, 1'b0, 1'b0);
        tick_at(32'd5100, 1'b0, 1'b0, 1'b0);
        tick_at(32'd5200, 1'b0, 1'b0, 1'b1);
        tick_at(32'd8199, 1'b0, 1'b0, 1'b1);
        tick_at(32'd8200, 1'b0, 1'b0, 1'b1);
    endtask

    // timestamps across the 2^32 wrap, pickup timeout, closing timeout
    task automatic test_wrap_and_short_timeouts();
        set_config(1'b0, 20'd10, 20'd20, 20'd10, 20'd5);
        tick_at(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0);
        send_request();
        tick_at(32'hFFFF_FFF2, 1'b0, 1'b0, 1'b0);
        tick_at(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        tick_at(32'h0000_0012, 1'b1, 1'b1, 1'b0);
        tick_at(32'h0000_0013, 1'b1, 1'b1, 1'b0);
        tick(32'd9, 1'b1, 1'b0, 1'b0);
        tick(32'd1, 1'b1, 1'b0, 1'b0);
        tick(32'd1, 1'b1, 1'b1, 1'b1);
        tick(32'd5, 1'b1, 1'b1, 1'b1);
        tick(32'd5, 1'b0, 1'b0, 1'b1);
        tick(32'd0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_item_sensor();
        set_config(1'b1, 20'd50, 20'd50, 20'd50, 20'd5);
        send_request();
        tick(32'd1, 1'b0, 1'b0, 1'b0);
        tick(32'd1, 1'b1, 1'b0, 1'b0);
        tick(32'd1, 1'b1, 1'b1, 1'b0);
        tick(32'd1, 1'b1, 1'b0, 1'b0);
        tick(32'd1, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_timeout_extremes();
        set_config(1'b0, '0, '0, '0, '0);
        send_request();
        tick(32'd1, 1'b0, 1'b0, 1'b0);
        tick(32'd0, 1'b0, 1'b0, 1'b0);
        tick(32'd0, 1'b0, 1'b0, 1'b1);
        tick(32'd0, 1'b0, 1'b0, 1'b1);
        set_config(1'b1, '1, '1, '1, '1);
        send_request();
        tick(32'd1, 1'b0, 1'b0, 1'b0);
        tick(32'd1048574, 1'b0, 1'b1, 1'b0);
        tick(32'd1, 1'b0, 1'b1, 1'b0);
    endtask

    // receiver parked long enough for the block to fill and push back
    task automatic test_backpressure();
        finish_results();
        rx_hold_req = 300;
        tx_steady   = 1'b1;
        repeat (48)
        begin
            if ($urandom_range(0, 3) == 0)
                send_request();
            else
                tick(pick_delta(), pick_bit(), pick_bit(), pick_bit());
        end
        tx_steady = 1'b0;
        finish_results();
    endtask

    task automatic test_random_traffic();
        int unsigned block_end;
        logic        key_mode;
        while (items_sent < ITEMS_TARGET)
        begin
            set_config(pick_bit(), pick_timeout(), pick_timeout(), pick_timeout(),
                       pick_timeout());
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            block_end = items_sent + $urandom_range(80, 160);
            while (items_sent < block_end)
            begin
                key_mode = ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 4) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_request();
                    else
                        tick(pick_delta(), pick_bit(), pick_bit(), pick_bit());
                end
                else
                begin
                    // one door cycle: request, unlock, door open, pickup, close
                    repeat ($urandom_range(1, 2)) send_request();
                    repeat ($urandom_range(0, 2))
                        tick(pick_delta(), 1'b0, pick_bit(),
                             key_mode ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0));
                    repeat ($urandom_range(1, 5))
                        tick(pick_delta(), 1'b1, ($urandom_range(0, 3) != 0),
                             key_mode ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0));
                    repeat ($urandom_range(0, 3))
                        tick(pick_delta(), 1'b1, 1'b0,
                             key_mode ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0));
                    repeat ($urandom_range(1, 3))
                        tick(pick_delta(), 1'b0, 1'b0,
                             key_mode ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0));
                end
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // receiver
    initial
    begin
        int unsigned n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req != 0)
            begin
                n = rx_hold_req;
                rx_hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            else if (rx_steady || $urandom_range(0, 3) != 0)
                m_axis_tready <= 1'b1;
            else
            begin
                n = pick_gap() + 1;
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (door_results_q.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_CAP)
                    $display("%0t: result transfer with nothing expected, expected none actual %0h",
                             $time, m_axis_tdata);
            end
            else
            begin
                want = door_results_q.pop_front();
                check_field("cabinet_state", 32'(want.cabinet_state), 32'(m_axis_tdata[2:0]));
                check_field("fault_cause", 32'(want.fault_cause), 32'(m_axis_tdata[4:3]));
                check_field("unlock_pulse", 32'(want.unlock_pulse), 32'(m_axis_tdata[5]));
                check_field("lock_pulse", 32'(want.lock_pulse), 32'(m_axis_tdata[6]));
                check_field("persist_code", 32'(want.persist_code), 32'(m_axis_tdata[8:7]));
                check_field("request_accepted", 32'(want.request_accepted),
                            32'(m_axis_tdata[9]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("locker_door_sequencer_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        tb_now        = '0;
        items_sent    = 0;
        error_count   = 0;
        idle_cycles   = 0;
        rx_hold_req   = 0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        lk_state      = ST_CLOSED;
        lk_fault      = FC_NONE;
        lk_entry      = '0;
        lk_pending    = 1'b0;
        lk_key_held   = 1'b0;
        lk_key_t      = '0;
        cf_use_item   = 1'b0;
        cf_open_tmo   = RST_OPEN_LIMIT_MS;
        cf_pickup_tmo = RST_PICKUP_LIMIT_MS;
        cf_close_tmo  = RST_CLOSE_LIMIT_MS;
        cf_key_clear  = RST_KEY_CLEAR_MS;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_wrap_and_short_timeouts();
        test_item_sensor();
        test_timeout_extremes();
        test_backpressure();
        test_random_traffic();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (door_results_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("locker_door_sequencer_unit verification clean");
        else
            $display("locker_door_sequencer_unit verification failed");
        $finish;
    end

endmodule
